// ----- rtl/bmsu_pkg.sv -----
// Shared types and constants of the batch median select unit.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package bmsu_pkg;

    localparam int SAMPLE_W    = 64;
    localparam int COUNT_OUT_W = 7;

    // One input transfer: a sample and the batch-close mark.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } sample_item_t;

    // One result transfer.
    typedef struct packed {
        logic [SAMPLE_W-1:0]    median_value;
        logic [COUNT_OUT_W-1:0] batch_count;
        logic                   dropped;
    } result_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_PLACE,
        ST_MED_HI,
        ST_MED_CAP,
        ST_MED_LO,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take the input transfer, start the insert scan at the top
        logic rd_scan;  // read the entry just below the insert position
        logic shift;    // move the entry read one place up, step the position down
        logic place;    // write the sample at the insert position, grow the count
        logic rd_hi;    // read the upper middle entry
        logic cap_hi;   // capture upper middle into both operands
        logic rd_lo;    // read the lower middle entry
        logic cap_lo;   // capture lower middle
        logic emit;     // load the result register, clear the batch
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;     // store holds the maximum number of samples
        logic empty;    // store holds no sample
        logic greater;  // entry read is greater than the held sample
        logic pos_one;  // insert position is one
        logic last;     // held item closes the batch
        logic in_last;  // offered input transfer closes the batch
        logic odd;      // kept count is odd
        logic out_free; // result register can take a new result this cycle
    } dp_status_t;

endpackage

// ----- rtl/bmsu_datapath.sv -----
// Datapath of the batch median select unit: sample store, insert position,
// count, median operands and the result register. Depends on bmsu_pkg.
`timescale 1ns / 1ps

module bmsu_datapath
    import bmsu_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  sample_item_t sample_data,
    input  dp_cmd_t      cmd,
    output dp_status_t   status,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_data
);

    localparam int IDX_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    logic [SAMPLE_W-1:0] store_mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;
    logic [SAMPLE_W-1:0] hi_reg;
    logic [SAMPLE_W-1:0] lo_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic                ovf_reg;
    logic                result_valid_reg;
    result_item_t        result_reg;

    logic [CNT_W-1:0]    pos_m1;
    logic [CNT_W-1:0]    half;
    logic [CNT_W-1:0]    half_m1;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [SAMPLE_W-1:0] median;

    assign pos_m1  = pos_reg - CNT_W'(1);
    assign half    = count_reg >> 1;
    assign half_m1 = half - CNT_W'(1);

    assign wr_en   = cmd.shift | cmd.place;
    assign wr_addr = pos_reg[IDX_W-1:0];
    assign wr_data = cmd.shift ? rd_data_reg : sample_reg;

    assign rd_en   = cmd.rd_scan | cmd.rd_hi | cmd.rd_lo;

    always_comb
    begin
        if (cmd.rd_scan)
        begin
            rd_addr = pos_m1[IDX_W-1:0];
        end
        else if (cmd.rd_hi)
        begin
            rd_addr = half[IDX_W-1:0];
        end
        else
        begin
            rd_addr = half_m1[IDX_W-1:0];
        end
    end

    // Single write port, single registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample_data.sample;
            last_reg   <= sample_data.last_sample;
        end
        if (cmd.cap_hi)
        begin
            hi_reg <= rd_data_reg;
            lo_reg <= rd_data_reg;
        end
        if (cmd.cap_lo)
        begin
            lo_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            result_reg.median_value <= median;
            result_reg.batch_count  <= COUNT_OUT_W'(count_reg);
            result_reg.dropped      <= ovf_reg;
        end
    end

    // Floor of the mean without a carry out of 64 bits.
    assign median = (lo_reg >> 1) + (hi_reg >> 1)
                  + {{(SAMPLE_W-1){1'b0}}, lo_reg[0] & hi_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            pos_reg          <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                pos_reg <= count_reg;
                if (status.full)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            else if (cmd.shift)
            begin
                pos_reg <= pos_m1;
            end

            if (cmd.place)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.emit)
            begin
                count_reg <= '0;
            end

            if (cmd.emit)
            begin
                ovf_reg <= 1'b0;
            end

            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign status.full     = (count_reg == CNT_W'(MAX_SAMPLES));
    assign status.empty    = (count_reg == '0);
    assign status.greater  = (rd_data_reg > sample_reg);
    assign status.pos_one  = (pos_reg == CNT_W'(1));
    assign status.last     = last_reg;
    assign status.in_last  = sample_data.last_sample;
    assign status.odd      = count_reg[0];
    assign status.out_free = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

// ----- rtl/bmsu_ctrl.sv -----
// Controller of the batch median select unit: sequences insert scan,
// median reads and result load. Depends on bmsu_pkg.
`timescale 1ns / 1ps

module bmsu_ctrl
    import bmsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_stall = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.full)
                    begin
                        // drop the sample; a closing item still reports
                        state_next = status.in_last ? ST_MED_HI : ST_IDLE;
                    end
                    else if (status.empty)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (status.greater)
                begin
                    cmd.shift  = 1'b1;
                    state_next = status.pos_one ? ST_PLACE : ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = status.last ? ST_MED_HI : ST_IDLE;
            end
            ST_MED_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_MED_CAP;
            end
            ST_MED_CAP:
            begin
                cmd.cap_hi = 1'b1;
                if (status.odd)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.rd_lo  = 1'b1;
                    state_next = ST_MED_LO;
                end
            end
            ST_MED_LO:
            begin
                cmd.cap_lo = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/batch_median_select_unit.sv -----
// Top level of the batch median select unit: joins controller and datapath.
// Depends on bmsu_pkg, bmsu_ctrl and bmsu_datapath.
`timescale 1ns / 1ps

// Batch median select unit. Each input transfer carries one unsigned 64-bit
// sample; the unit keeps the samples of the current batch in ascending
// order in a single-port store of MAX_SAMPLES entries by insertion: the new
// sample starts at the top and every larger entry moves up one place, one
// read and one write per step. A transfer marked last_sample closes the
// batch and produces one result: the middle sample for an odd count, or the
// floor of the mean of the two middle samples for an even count (the sum
// never wraps), with the kept count and a flag that shows whether samples
// were dropped because the store was full. The count and flag then clear.
// Each insert step reads the entry below the insert position (ST_SCAN_RD)
// and moves it up if it is larger (ST_SCAN_CMP); the scan ends at an entry
// that is not larger or at the bottom, and ST_PLACE writes the sample. A
// dropped sample skips the scan. Each step needs a read and a compare
// state as the store has registered read data. A closing transfer then
// runs ST_MED_HI, ST_MED_CAP, ST_MED_LO (even count only) and ST_EMIT,
// which waits while the previous result is still held. The result sits
// in an output register, so a stalled result never blocks the next batch
// until its own result is ready. The store needs no clearing.

module batch_median_select_unit
    import bmsu_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_item_t sample_data,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence the insert scan and the median reads.
    bmsu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Hold the sorted store, count, drop flag and result register.
    bmsu_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_data  (sample_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule
